### rtl/core/reliable_chunk_deframer_assert.svh
// Assertion macros for the reliable chunk deframer
`ifndef RELIABLE_CHUNK_DEFRAMER_ASSERT_SVH
`define RELIABLE_CHUNK_DEFRAMER_ASSERT_SVH

// Checked outside reset
`define RCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define RCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/rcd_pkg.sv
// Shared constants, codes and result type for the reliable chunk deframer
`default_nettype none

package rcd_pkg;

  localparam int SEQ_WINDOW       = 1024;
  localparam int SEQ_W            = $clog2(SEQ_WINDOW);
  localparam int MAX_PACKET_BYTES = 2048;

  localparam int BYTE_W  = 8;
  localparam int PKT_W   = 12;
  localparam int CNT_W   = 8;
  localparam int SIZE_W  = 10;
  localparam int FSEQ_W  = 10;
  localparam int FLAG_W  = 2;
  localparam int KIND_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    EV_HEADER = 3'd0,
    EV_BYTE   = 3'd1,
    EV_OLD    = 3'd2,
    EV_RESEND = 3'd3,
    EV_TRUNC  = 3'd4
  } event_kind_t;

  typedef struct packed {
    event_kind_t              kind;
    logic [BYTE_W-1:0]        data;
    logic [FLAG_W-1:0]        flags;
    logic [SIZE_W-1:0]        size;
    logic [FSEQ_W-1:0]        seq;
    logic [FSEQ_W-1:0]        expected;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/reliable_chunk_deframer.sv
// Reliable chunk deframer: splits a packet's chunk area into sequenced chunks
//
//   channel | direction | words                              | handshake
//   --------+-----------+------------------------------------+-------------------
//   in      | input     | data_byte, packet_start, sizes     | in_valid/in_stall
//   out     | output    | event_kind, payload and header info | out_valid/out_stall
//
// One word per cycle while in_stall is low: header/payload parse and ack
// update are one level of logic from the parse registers into the result register.
// When the output is free, an accepted word's result goes straight into out_q.
// A two-entry output (result register plus skid) lets input flow while a
// result waits; in_stall rises only once the skid entry is occupied.
// Synchronous reset clears the parse state, ack and both output entries.
`default_nettype none

module reliable_chunk_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rcd_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          packet_start,
  input  wire logic [rcd_pkg::PKT_W-1:0]     packet_bytes,
  input  wire logic [rcd_pkg::CNT_W-1:0]     chunk_count,
  input  wire logic                          connected,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rcd_pkg::KIND_W-1:0]         event_kind,
  output logic [rcd_pkg::BYTE_W-1:0]         payload_byte,
  output logic [rcd_pkg::FLAG_W-1:0]         chunk_flags,
  output logic [rcd_pkg::SIZE_W-1:0]         chunk_size,
  output logic [rcd_pkg::FSEQ_W-1:0]         chunk_sequence,
  output logic [rcd_pkg::FSEQ_W-1:0]         expected_sequence,
  output logic                               last_of_chunk
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_PAYLOAD
  } phase_t;

  localparam int HALF = rcd_pkg::SEQ_WINDOW / 2;

  phase_t                         phase, phase_next;
  logic [rcd_pkg::BYTE_W-1:0]     hdr0, hdr0_next;
  logic [rcd_pkg::BYTE_W-1:0]     hdr1, hdr1_next;
  logic [rcd_pkg::PKT_W-1:0]      pkt_rem, pkt_rem_next;
  logic [rcd_pkg::CNT_W-1:0]      chunks_rem, chunks_rem_next;
  logic [rcd_pkg::SIZE_W-1:0]     pay_rem, pay_rem_next;
  logic                           skipping, skipping_next;
  logic                           conn, conn_next;
  logic [rcd_pkg::FSEQ_W-1:0]     seq, seq_next;
  logic [rcd_pkg::SEQ_W-1:0]      ack, ack_next;

  logic                           res_valid;
  rcd_pkg::result_t               res;
  rcd_pkg::result_t               out_q, skid_q;
  logic                           skid_valid;
  logic                           accept;
  logic                           out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  function automatic logic [rcd_pkg::SEQ_W-1:0] seq_inc(input logic [rcd_pkg::SEQ_W-1:0] a);
    return (a == rcd_pkg::SEQ_W'(rcd_pkg::SEQ_WINDOW - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic in_backroom(input logic [rcd_pkg::FSEQ_W-1:0] s,
                                       input logic [rcd_pkg::SEQ_W-1:0] a);
    logic [12:0] s13, a13;
    begin
      s13 = 13'(s);
      a13 = 13'(a);
      if (a13 >= 13'(HALF)) begin
        in_backroom = (s13 <= a13) && (s13 >= a13 - 13'(HALF));
      end else begin
        in_backroom = (s13 <= a13) || (s13 >= a13 + 13'(HALF));
      end
    end
  endfunction

  // Parse step for one word
  always_comb begin
    logic [rcd_pkg::SIZE_W-1:0]   size;
    logic                         vital;
    logic [rcd_pkg::SEQ_W-1:0]    exp;
    logic                         done;
    logic                         drop;
    rcd_pkg::event_kind_t         kind;
    logic [rcd_pkg::BYTE_W-1:0]   pbyte;
    logic                         last;

    phase_next      = phase;
    hdr0_next       = hdr0;
    hdr1_next       = hdr1;
    pkt_rem_next    = pkt_rem;
    chunks_rem_next = chunks_rem;
    pay_rem_next    = pay_rem;
    skipping_next   = skipping;
    conn_next       = conn;
    seq_next        = seq;
    ack_next        = ack;
    res_valid       = 1'b0;
    done            = 1'b0;
    drop            = 1'b0;
    kind            = rcd_pkg::EV_TRUNC;
    pbyte           = '0;
    last            = 1'b0;
    size            = '0;
    vital           = 1'b0;
    exp             = '0;

    if (packet_start) begin
      pkt_rem_next    = (packet_bytes > rcd_pkg::PKT_W'(rcd_pkg::MAX_PACKET_BYTES)) ?
                        rcd_pkg::PKT_W'(rcd_pkg::MAX_PACKET_BYTES) : packet_bytes;
      chunks_rem_next = chunk_count;
      conn_next       = connected;
      skipping_next   = 1'b0;
      pay_rem_next    = '0;
      hdr0_next       = '0;
      hdr1_next       = '0;
      seq_next        = '0;
      phase_next      = (pkt_rem_next == '0 || chunk_count == '0) ? PH_IDLE : PH_HDR0;
    end

    if (phase_next == PH_IDLE || pkt_rem_next == '0) begin
      phase_next = PH_IDLE;
    end else begin
      pkt_rem_next = pkt_rem_next - 1'b1;
      unique case (phase_next)
        PH_HDR0: begin
          hdr0_next = data_byte;
          hdr1_next = '0;
          seq_next  = '0;
          if (pkt_rem_next == '0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          hdr1_next = data_byte;
          if (hdr0_next[6]) begin
            if (pkt_rem_next == '0) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
            end else begin
              phase_next = PH_HDR2;
            end
          end else begin
            done = 1'b1;
          end
        end
        PH_HDR2: begin
          seq_next = {hdr1_next[7:4], 6'b0} | {2'b0, data_byte};
          done     = 1'b1;
        end
        PH_PAYLOAD: begin
          pay_rem_next = pay_rem_next - 1'b1;
          last         = (pay_rem_next == '0);
          if (last) begin
            phase_next = (chunks_rem_next == '0 || pkt_rem_next == '0) ? PH_IDLE : PH_HDR0;
          end
          if (!skipping_next) begin
            res_valid = 1'b1;
            kind      = rcd_pkg::EV_BYTE;
            pbyte     = data_byte;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // Complete header
      if (done) begin
        size  = {hdr0_next[5:0], hdr1_next[3:0]};
        vital = hdr0_next[6];
        res_valid = 1'b1;
        if (12'(size) > pkt_rem_next) begin
          phase_next = PH_IDLE;
          kind       = rcd_pkg::EV_TRUNC;
        end else begin
          chunks_rem_next = chunks_rem_next - 1'b1;
          exp = seq_inc(ack_next);
          if (conn_next && vital) begin
            if (11'(seq_next) == 11'(exp)) begin
              ack_next = exp;
            end else begin
              drop = 1'b1;
              kind = in_backroom(seq_next, ack_next) ? rcd_pkg::EV_OLD : rcd_pkg::EV_RESEND;
            end
          end
          if (!drop) begin
            kind = rcd_pkg::EV_HEADER;
            last = (size == '0);
          end
          if (size == '0) begin
            phase_next = (chunks_rem_next == '0 || pkt_rem_next == '0) ? PH_IDLE : PH_HDR0;
          end else begin
            phase_next    = PH_PAYLOAD;
            pay_rem_next  = size;
            skipping_next = drop;
          end
        end
      end
    end

    res.kind     = kind;
    res.data     = pbyte;
    res.flags    = hdr0_next[7:6];
    res.size     = {hdr0_next[5:0], hdr1_next[3:0]};
    res.seq      = hdr0_next[6] ? seq_next : '0;
    res.expected = rcd_pkg::FSEQ_W'(seq_inc(ack_next));
    res.last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hdr0       <= '0;
      hdr1       <= '0;
      pkt_rem    <= '0;
      chunks_rem <= '0;
      pay_rem    <= '0;
      skipping   <= 1'b0;
      conn       <= 1'b0;
      seq        <= '0;
      ack        <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        hdr0       <= hdr0_next;
        hdr1       <= hdr1_next;
        pkt_rem    <= pkt_rem_next;
        chunks_rem <= chunks_rem_next;
        pay_rem    <= pay_rem_next;
        skipping   <= skipping_next;
        conn       <= conn_next;
        seq        <= seq_next;
        ack        <= ack_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept && res_valid) begin
          out_q     <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign event_kind        = out_q.kind;
  assign payload_byte      = out_q.data;
  assign chunk_flags       = out_q.flags;
  assign chunk_size        = out_q.size;
  assign chunk_sequence    = out_q.seq;
  assign expected_sequence = out_q.expected;
  assign last_of_chunk     = out_q.last;

  `include "reliable_chunk_deframer_assert.svh"

  `RCD_ASSERT_ALWAYS(a_skid_implies_out, (!skid_valid || out_valid || rst), "skid full with output empty")
  `RCD_ASSERT(a_skid_fill, (accept && res_valid && out_valid && out_stall) |=> skid_valid, "result lost on stalled output")
  `RCD_ASSERT(a_payload_count, (phase == PH_PAYLOAD) |-> (pay_rem != '0), "payload phase with zero count")
  `RCD_ASSERT(a_ack_hold, !accept |=> $stable(ack), "ack moved without an accepted word")
  `RCD_ASSERT(a_trunc_not_last, (out_valid && event_kind == rcd_pkg::EV_TRUNC) |-> !last_of_chunk, "truncated event flagged last")

endmodule

`default_nettype wire
